// ===== rtl/core/tridiagonal_thomas_solver_core_assert.svh =====
// Assertion macros shared by the tridiagonal solver RTL
`ifndef TRIDIAGONAL_THOMAS_SOLVER_CORE_ASSERT_SVH
`define TRIDIAGONAL_THOMAS_SOLVER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define TTS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tts assertion failed");

// Next-cycle implication, checked out of reset
`define TTS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tts assertion failed");

`endif

// ===== rtl/core/tts_pkg.sv =====
// Shared constants and types of the tridiagonal solver
`default_nettype none
package tts_pkg;
   localparam int MAX_ROWS  = 64;
   localparam int FRAC_BITS = 16;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int CNT_W     = ROW_W + 1;
   localparam int DEN_W     = 33;
   localparam int DIVN_W    = DEN_W + FRAC_BITS + 1;
   localparam int DSTEP_W   = $clog2(DIVN_W);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef logic signed [31:0]      q_type;
   typedef logic signed [DEN_W-1:0] wide_type;
endpackage
`default_nettype wire

// ===== rtl/core/tts_divider.sv =====
// Restoring divider, one quotient bit per cycle
`default_nettype none
module tts_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tts_pkg::DIVN_W-1:0] dividend,
   input  wire logic [tts_pkg::DEN_W-1:0]  divisor,
   output logic                            done,
   output logic [tts_pkg::DIVN_W-1:0]      quotient
);
   import tts_pkg::*;

   logic                 run_ff, run_in;
   logic [DSTEP_W-1:0]   step_ff, step_in;
   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [DIVN_W-1:0]    quo_ff, quo_in;
   logic [DEN_W-1:0]     dvs_ff, dvs_in;
   logic                 done_ff, done_in;
   logic [DEN_W:0]       trial;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DIVN_W-1]};
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (run_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[DIVN_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == DSTEP_W'(DIVN_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `include "tridiagonal_thomas_solver_core_assert.svh"
   `TTS_ASSERT_IMP(a_no_restart, run_ff, !start)
   `TTS_ASSERT_IMP(a_rem_below, run_ff, rem_ff < dvs_ff)
   `TTS_ASSERT_NXT(a_done_once, done_ff, !done_ff)
endmodule
`default_nettype wire

// ===== rtl/core/tridiagonal_thomas_solver_core.sv =====
// Top level of the tridiagonal (Thomas) solver
// Rows arrive one per start beat while busy is low. For a row after the first, the shared
// 32x32 multiplier is used twice and the pivot is formed and checked in the S_MULS,
// S_MULR, S_PIV and S_CHECK states. Then two 50-step divisions run on one restoring
// divider (one quotient bit per cycle). Row 0 skips the multiplies. The last row needs
// only the right-hand-side division. After it, results are emitted from the last row
// down to row 0, back substitution forming each earlier row in a pass through S_BRD,
// S_BMUL and S_BSUB. Rows dropped after a failure and overflow reports leave the block
// free at once. A singular pivot is reported after the pivot check. Results appear on
// rsp_* for exactly one cycle with rsp_valid high; the receiver cannot stall.
`default_nettype none
module tridiagonal_thomas_solver_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic signed [31:0]        req_sub_diag,
   input  wire logic signed [31:0]        req_main_diag,
   input  wire logic signed [31:0]        req_super_diag,
   input  wire logic signed [31:0]        req_rhs_value,
   input  wire logic                      req_last_row,
   output logic                           rsp_valid,
   output logic signed [31:0]             rsp_solution_value,
   output logic [tts_pkg::ROW_W-1:0]      rsp_row_index,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_last_result,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [30:0]               csr_pivot_threshold
);
   import tts_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MULS  = 4'd1;
   localparam logic [3:0] S_MULR  = 4'd2;
   localparam logic [3:0] S_PIV   = 4'd3;
   localparam logic [3:0] S_CHECK = 4'd4;
   localparam logic [3:0] S_DIVS  = 4'd5;
   localparam logic [3:0] S_DIVR  = 4'd6;
   localparam logic [3:0] S_BRD   = 4'd7;
   localparam logic [3:0] S_BMUL  = 4'd8;
   localparam logic [3:0] S_BSUB  = 4'd9;

   // Round half away from zero and saturate a Q product
   function automatic q_type mulq_round(input logic signed [63:0] p);
      logic [63:0] m;
      logic [63:0] r;
      logic signed [64:0] s;
      m = p[63] ? 64'(-p) : 64'(p);
      r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      s = p[63] ? -$signed({1'b0, r}) : $signed({1'b0, r});
      if (s > 65'sd2147483647) mulq_round = 32'sh7fffffff;
      else if (s < -65'sd2147483648) mulq_round = 32'sh80000000;
      else mulq_round = s[31:0];
   endfunction

   // Clamp and sign a quotient magnitude
   function automatic q_type div_finish(input logic [DIVN_W-1:0] q, input logic neg);
      logic [DIVN_W-1:0] c;
      c = (q > DIVN_W'(64'h80000000)) ? DIVN_W'(64'h80000000) : q;
      if (neg) div_finish = 32'(-c);
      else if (c[31]) div_finish = 32'sh7fffffff;
      else div_finish = c[31:0];
   endfunction

   // Saturate a 33-bit difference to 32 bits
   function automatic q_type sat33(input wide_type v);
      if (v > 33'sd2147483647) sat33 = 32'sh7fffffff;
      else if (v < -33'sd2147483648) sat33 = 32'sh80000000;
      else sat33 = v[31:0];
   endfunction

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [1:0]          failed_ff, failed_in;
   logic [30:0]         thr_ff, thr_in;
   logic [ROW_W-1:0]    k_ff, k_in;
   q_type               lower_ff, lower_in, diag_ff, diag_in;
   q_type               upper_ff, upper_in, rhs_ff, rhs_in;
   logic                last_ff, last_in;
   wide_type            denom_ff, denom_in, num_ff, num_in;
   q_type               sup_ff, sup_in, next_ff, next_in;
   logic signed [63:0]  prod_ff, prod_in;
   logic                rv_ff, rv_in, rl_ff, rl_in;
   q_type               rval_ff, rval_in;
   logic [ROW_W-1:0]    rrow_ff, rrow_in;
   logic [1:0]          rst_ff, rst_in;

   // Coefficient stores
   q_type               msup_mem [MAX_ROWS];
   q_type               mrhs_mem [MAX_ROWS];
   q_type               msup_rd_ff, mrhs_rd_ff;
   logic [ROW_W-1:0]    rd_addr;
   logic [CNT_W-1:0]    cnt_m1;
   logic                wr_en;

   // Shared divider hookup
   logic                div_start, div_done;
   logic [DIVN_W-1:0]   div_q, div_dividend;
   logic [DEN_W-1:0]    den_mag, num_mag;
   wide_type            div_num;
   logic                div_neg_ff, div_neg_in;

   logic signed [31:0]  mul_a, mul_b;
   logic                accept, backsub;

   assign accept  = start && (state_ff == S_IDLE);
   assign busy    = (state_ff != S_IDLE);
   assign backsub = (state_ff == S_BRD) || (state_ff == S_BMUL) || (state_ff == S_BSUB);
   assign cnt_m1  = count_ff - 1'b1;
   assign rd_addr = backsub ? k_ff : cnt_m1[ROW_W-1:0];
   assign csr_ready = 1'b1;

   assign den_mag = denom_ff[DEN_W-1] ? DEN_W'(-denom_ff) : DEN_W'(denom_ff);
   assign div_num = (state_ff == S_CHECK && !last_ff) ? DEN_W'(upper_ff) : num_ff;
   assign num_mag = div_num[DEN_W-1] ? DEN_W'(-div_num) : DEN_W'(div_num);
   assign div_dividend = DIVN_W'({num_mag, FRAC_BITS'(0)}) + DIVN_W'(den_mag >> 1);

   tts_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_mag),
      .done     (div_done),
      .quotient (div_q)
   );

   // Pick multiplier operands per phase
   always_comb begin
      mul_a = lower_ff;
      mul_b = msup_rd_ff;
      unique case (state_ff)
         S_MULR:  mul_b = mrhs_rd_ff;
         S_BMUL:  begin
            mul_a = msup_rd_ff;
            mul_b = next_ff;
         end
         default: mul_b = msup_rd_ff;
      endcase
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      failed_in  = failed_ff;
      thr_in     = csr_valid ? csr_pivot_threshold : thr_ff;
      k_in       = k_ff;
      lower_in   = lower_ff;
      diag_in    = diag_ff;
      upper_in   = upper_ff;
      rhs_in     = rhs_ff;
      last_in    = last_ff;
      denom_in   = denom_ff;
      num_in     = num_ff;
      sup_in     = sup_ff;
      next_in    = next_ff;
      prod_in    = mul_a * mul_b;
      rv_in      = 1'b0;
      rl_in      = 1'b0;
      rval_in    = '0;
      rrow_in    = '0;
      rst_in     = STATUS_OK;
      div_start  = 1'b0;
      div_neg_in = div_neg_ff;
      wr_en      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lower_in = req_sub_diag;
               diag_in  = req_main_diag;
               upper_in = req_super_diag;
               rhs_in   = req_rhs_value;
               last_in  = req_last_row;
               if (failed_ff != 2'd0) begin
                  // drop rows until the run's last one
                  if (req_last_row) begin
                     count_in  = '0;
                     failed_in = 2'd0;
                  end
               end else if (count_ff >= CNT_W'(MAX_ROWS)) begin
                  rv_in   = 1'b1;
                  rrow_in = ROW_W'(MAX_ROWS - 1);
                  rst_in  = STATUS_OVERFLOW;
                  rl_in   = 1'b1;
                  if (req_last_row) begin
                     count_in  = '0;
                     failed_in = 2'd0;
                  end else begin
                     failed_in = STATUS_OVERFLOW;
                  end
               end else if (count_ff == '0) begin
                  denom_in = DEN_W'(req_main_diag);
                  num_in   = DEN_W'(req_rhs_value);
                  state_in = S_CHECK;
               end else begin
                  state_in = S_MULS;
               end
            end
         end
         S_MULS: state_in = S_MULR;
         S_MULR: begin
            denom_in = DEN_W'(diag_ff) - DEN_W'(mulq_round(prod_ff));
            state_in = S_PIV;
         end
         S_PIV: begin
            num_in   = DEN_W'(rhs_ff) - DEN_W'(mulq_round(prod_ff));
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (denom_ff == '0 || den_mag < DEN_W'(thr_ff)) begin
               rv_in    = 1'b1;
               rrow_in  = count_ff[ROW_W-1:0];
               rst_in   = STATUS_SINGULAR;
               rl_in    = 1'b1;
               state_in = S_IDLE;
               if (last_ff) begin
                  count_in  = '0;
                  failed_in = 2'd0;
               end else begin
                  failed_in = STATUS_SINGULAR;
               end
            end else begin
               div_start  = 1'b1;
               div_neg_in = div_num[DEN_W-1] ^ denom_ff[DEN_W-1];
               if (last_ff) begin
                  sup_in   = '0;
                  state_in = S_DIVR;
               end else begin
                  state_in = S_DIVS;
               end
            end
         end
         S_DIVS: begin
            if (div_done) begin
               sup_in     = div_finish(div_q, div_neg_ff);
               div_start  = 1'b1;
               div_neg_in = num_ff[DEN_W-1] ^ denom_ff[DEN_W-1];
               state_in   = S_DIVR;
            end
         end
         S_DIVR: begin
            if (div_done) begin
               wr_en    = 1'b1;
               next_in  = div_finish(div_q, div_neg_ff);
               count_in = count_ff + 1'b1;
               state_in = S_IDLE;
               if (last_ff) begin
                  rv_in   = 1'b1;
                  rval_in = div_finish(div_q, div_neg_ff);
                  rrow_in = count_ff[ROW_W-1:0];
                  rl_in   = (count_ff == '0);
                  if (count_ff == '0) begin
                     count_in = '0;
                  end else begin
                     k_in     = cnt_m1[ROW_W-1:0];
                     state_in = S_BRD;
                  end
               end
            end
         end
         S_BRD:  state_in = S_BMUL;
         S_BMUL: state_in = S_BSUB;
         S_BSUB: begin
            // back-substitute one row and emit it
            next_in = sat33(DEN_W'(mrhs_rd_ff) - DEN_W'(mulq_round(prod_ff)));
            rv_in   = 1'b1;
            rval_in = next_in;
            rrow_in = k_ff;
            rl_in   = (k_ff == '0);
            if (k_ff == '0) begin
               count_in  = '0;
               failed_in = 2'd0;
               state_in  = S_IDLE;
            end else begin
               k_in     = k_ff - 1'b1;
               state_in = S_BRD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         msup_mem[count_ff[ROW_W-1:0]] <= sup_ff;
         mrhs_mem[count_ff[ROW_W-1:0]] <= next_in;
      end
      msup_rd_ff <= msup_mem[rd_addr];
      mrhs_rd_ff <= mrhs_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         failed_ff <= 2'd0;
         thr_ff    <= 31'd1;
         rv_ff     <= 1'b0;
         next_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         failed_ff <= failed_in;
         thr_ff    <= thr_in;
         rv_ff     <= rv_in;
         next_ff   <= next_in;
      end
      k_ff       <= k_in;
      lower_ff   <= lower_in;
      diag_ff    <= diag_in;
      upper_ff   <= upper_in;
      rhs_ff     <= rhs_in;
      last_ff    <= last_in;
      denom_ff   <= denom_in;
      num_ff     <= num_in;
      sup_ff     <= sup_in;
      prod_ff    <= prod_in;
      div_neg_ff <= div_neg_in;
      rl_ff      <= rl_in;
      rval_ff    <= rval_in;
      rrow_ff    <= rrow_in;
      rst_ff     <= rst_in;
   end

   assign rsp_valid          = rv_ff;
   assign rsp_solution_value = rval_ff;
   assign rsp_row_index      = rrow_ff;
   assign rsp_status         = rst_ff;
   assign rsp_last_result    = rl_ff;

   `include "tridiagonal_thomas_solver_core_assert.svh"
   `TTS_ASSERT_IMP(a_fail_is_last, rv_ff && rst_ff != STATUS_OK, rl_ff)
   `TTS_ASSERT_IMP(a_ovf_row, rv_ff && rst_ff == STATUS_OVERFLOW, rrow_ff == ROW_W'(MAX_ROWS - 1))
   `TTS_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(MAX_ROWS))
   `TTS_ASSERT_IMP(a_fail_idle, failed_ff != 2'd0, state_ff == S_IDLE)
endmodule
`default_nettype wire
